// ----- src/perspective_world_to_screen_defines.svh -----
// ----------------------------------------------------------------------------
// perspective_world_to_screen assertion macros
// shared concurrent assertion forms for the projection block
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_WORLD_TO_SCREEN_DEFINES_SVH
`define PERSPECTIVE_WORLD_TO_SCREEN_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PWS_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("pws assertion failed");

// next-cycle implication, checked outside reset
`define PWS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("pws assertion failed");

`endif

// ----- src/pws_pkg.sv -----
// ----------------------------------------------------------------------------
// pws_pkg
// widths, codes and shared types of the world-to-screen projection block
// ----------------------------------------------------------------------------
`default_nettype none

package pws_pkg;

   // point coordinate format
   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;

   // matrix storage
   localparam int COEF_BITS = 32;
   localparam int MAT_DEPTH = 16;
   localparam int IDX_BITS  = 4;

   // viewport registers
   localparam int DIM_BITS      = 14;
   localparam int HALF_BITS     = DIM_BITS - 1;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = DIM_BITS;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 14'd1920;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 14'd1080;

   // request opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   // datapath widths
   localparam int PROD_BITS = COEF_BITS + COORD_BITS;
   localparam int CLIP_BITS = PROD_BITS + 2;
   localparam int OFS_BITS  = HALF_BITS + FRAC_BITS;
   localparam int NUM_BITS  = CLIP_BITS + HALF_BITS + FRAC_BITS;
   localparam int QUO_BITS  = ((COORD_BITS > OFS_BITS) ? COORD_BITS : OFS_BITS) + 1;
   localparam int SUM_BITS  = QUO_BITS + 2;

   typedef struct packed {
      logic signed [CLIP_BITS-1:0] xc;
      logic signed [CLIP_BITS-1:0] yc;
      logic signed [CLIP_BITS-1:0] wc;
   } clip_type;

   typedef struct packed {
      logic vis;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } side_type;

   typedef struct packed {
      logic [CLIP_BITS-1:0] rx;
      logic [CLIP_BITS-1:0] ry;
      logic [CLIP_BITS-1:0] d;
      logic [QUO_BITS-1:0]  qx;
      logic [QUO_BITS-1:0]  qy;
      side_type             side;
   } div_type;

endpackage

`default_nettype wire

// ----- src/pws_if.sv -----
// ----------------------------------------------------------------------------
// pws channel interfaces
// request, response and register write channels of the projection block
// ----------------------------------------------------------------------------
`default_nettype none

interface pws_req_if;
   import pws_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [IDX_BITS-1:0]          coef_index;
   logic signed [COEF_BITS-1:0]  coef_value;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   modport source (output valid, opcode, coef_index, coef_value, pos_x, pos_y, pos_z,
                   input ready);
   modport sink (input valid, opcode, coef_index, coef_value, pos_x, pos_y, pos_z,
                 output ready);
endinterface

interface pws_rsp_if;
   import pws_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         visible;
   logic signed [COORD_BITS-1:0] screen_x;
   logic signed [COORD_BITS-1:0] screen_y;
   modport source (output valid, visible, screen_x, screen_y, input ready);
   modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface

interface pws_csr_if;
   import pws_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  addr;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ----- src/pws_clip.sv -----
// ----------------------------------------------------------------------------
// pws_clip
// matrix store and clip-space x, y, w as two pipeline stages
// ----------------------------------------------------------------------------
`default_nettype none

module pws_clip (
   input  wire logic            clock,
   input  wire logic            reset,
   pws_req_if.sink              req_chan,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output pws_pkg::clip_type    out_data
);
   import pws_pkg::*;

   logic signed [COEF_BITS-1:0]  mat_ff [MAT_DEPTH];
   logic signed [COORD_BITS-1:0] pos [3];
   logic signed [PROD_BITS-1:0]  prod_in [3][3];
   logic signed [PROD_BITS-1:0]  prod_ff [3][3];
   logic signed [COEF_BITS-1:0]  tr_in [3];
   logic signed [COEF_BITS-1:0]  tr_ff [3];
   logic signed [CLIP_BITS-1:0]  sum_in [3];
   logic                         v1_ff, v2_ff;
   logic                         rdy1, rdy2, accept;
   clip_type                     clip_ff;

   // stage handshake, bubbles collapse
   assign rdy2           = !v2_ff || out_ready;
   assign rdy1           = !v1_ff || rdy2;
   assign req_chan.ready = rdy1;
   assign accept         = req_chan.valid && rdy1;

   assign pos[0] = req_chan.pos_x;
   assign pos[1] = req_chan.pos_y;
   assign pos[2] = req_chan.pos_z;

   // coefficient writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_DEPTH; i++) mat_ff[i] <= '0;
      end else if (accept && req_chan.opcode == OP_LOAD) begin
         mat_ff[req_chan.coef_index] <= req_chan.coef_value;
      end
   end

   // products of rows x, y and w with the point
   for (genvar r = 0; r < 3; r++) begin : g_row
      localparam int ROW = (r == 2) ? 3 : r;
      for (genvar k = 0; k < 3; k++) begin : g_col
         assign prod_in[r][k] = mat_ff[ROW + 4 * k] * pos[k];
      end
      assign tr_in[r]  = mat_ff[ROW + 12];
      assign sum_in[r] = (CLIP_BITS'(tr_ff[r]) <<< FRAC_BITS)
                       + CLIP_BITS'(prod_ff[r][0]) + CLIP_BITS'(prod_ff[r][1])
                       + CLIP_BITS'(prod_ff[r][2]);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= accept && req_chan.opcode == OP_POINT;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (rdy1) begin
         prod_ff <= prod_in;
         tr_ff   <= tr_in;
      end
      if (rdy2) begin
         clip_ff.xc <= sum_in[0];
         clip_ff.yc <= sum_in[1];
         clip_ff.wc <= sum_in[2];
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = clip_ff;

endmodule

`default_nettype wire

// ----- src/pws_prep.sv -----
// ----------------------------------------------------------------------------
// pws_prep
// visibility test, scaling by the half extents and divider setup
// ----------------------------------------------------------------------------
`default_nettype none

module pws_prep (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire pws_pkg::clip_type             in_data,
   input  wire logic [pws_pkg::HALF_BITS-1:0] half_w,
   input  wire logic [pws_pkg::HALF_BITS-1:0] half_h,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output pws_pkg::div_type                   out_data
);
   import pws_pkg::*;

   localparam int W100_BITS = CLIP_BITS + 7;
   localparam int MUL_BITS  = CLIP_BITS + HALF_BITS;

   logic [CLIP_BITS-1:0]        ax, ay, wu;
   logic [W100_BITS-1:0]        w100, thr;
   logic [MUL_BITS-1:0]         mx_ff, my_ff;
   logic [CLIP_BITS-1:0]        d_ff;
   side_type                    side_ff;
   logic                        v3_ff, v4_ff;
   logic                        rdy3, rdy4;
   logic [NUM_BITS-1:0]         num_x, num_y;
   logic [CLIP_BITS-1:0]        hi_x, hi_y;
   div_type                     div_in, div_ff;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign in_ready = rdy3;

   // magnitudes and visibility test w * 100 >= 1
   assign ax   = in_data.xc[CLIP_BITS-1] ? CLIP_BITS'(-in_data.xc) : CLIP_BITS'(in_data.xc);
   assign ay   = in_data.yc[CLIP_BITS-1] ? CLIP_BITS'(-in_data.yc) : CLIP_BITS'(in_data.yc);
   assign wu   = CLIP_BITS'(in_data.wc);
   assign w100 = (W100_BITS'(wu) << 6) + (W100_BITS'(wu) << 5) + (W100_BITS'(wu) << 2);
   assign thr  = W100_BITS'(1) << (2 * FRAC_BITS);

   // dividend high part, overflow when quotient would not fit
   assign num_x = {mx_ff, {FRAC_BITS{1'b0}}};
   assign num_y = {my_ff, {FRAC_BITS{1'b0}}};
   assign hi_x  = CLIP_BITS'(num_x[NUM_BITS-1:QUO_BITS]);
   assign hi_y  = CLIP_BITS'(num_y[NUM_BITS-1:QUO_BITS]);

   always_comb begin
      div_in            = '0;
      div_in.rx         = hi_x;
      div_in.ry         = hi_y;
      div_in.d          = d_ff;
      div_in.qx         = num_x[QUO_BITS-1:0];
      div_in.qy         = num_y[QUO_BITS-1:0];
      div_in.side       = side_ff;
      div_in.side.ovf_x = hi_x >= d_ff;
      div_in.side.ovf_y = hi_y >= d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy3) v3_ff <= in_valid;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         mx_ff         <= ax * half_w;
         my_ff         <= ay * half_h;
         d_ff          <= wu;
         side_ff.vis   <= !in_data.wc[CLIP_BITS-1] && (w100 >= thr);
         side_ff.neg_x <= in_data.xc[CLIP_BITS-1];
         side_ff.neg_y <= in_data.yc[CLIP_BITS-1];
         side_ff.ovf_x <= 1'b0;
         side_ff.ovf_y <= 1'b0;
      end
      if (rdy4) div_ff <= div_in;
   end

   assign out_valid = v4_ff;
   assign out_data  = div_ff;

endmodule

`default_nettype wire

// ----- src/pws_div.sv -----
// ----------------------------------------------------------------------------
// pws_div
// pipelined restoring divider, one quotient bit per stage, x and y lanes
// ----------------------------------------------------------------------------
`default_nettype none

module pws_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire pws_pkg::div_type in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output pws_pkg::div_type out_data
);
   import pws_pkg::*;

   div_type st_ff [QUO_BITS];
   logic    v_ff  [QUO_BITS];
   logic    rdy   [QUO_BITS+1];

   // one bit of each quotient: shift in the next dividend bit, trial subtract
   function automatic div_type div_step(div_type s);
      div_type          o;
      logic [CLIP_BITS:0] tx, ty, dd;
      o  = s;
      dd = {1'b0, s.d};
      tx = {s.rx, s.qx[QUO_BITS-1]};
      ty = {s.ry, s.qy[QUO_BITS-1]};
      if (tx >= dd) begin
         o.rx = CLIP_BITS'(tx - dd);
         o.qx = {s.qx[QUO_BITS-2:0], 1'b1};
      end else begin
         o.rx = tx[CLIP_BITS-1:0];
         o.qx = {s.qx[QUO_BITS-2:0], 1'b0};
      end
      if (ty >= dd) begin
         o.ry = CLIP_BITS'(ty - dd);
         o.qy = {s.qy[QUO_BITS-2:0], 1'b1};
      end else begin
         o.ry = ty[CLIP_BITS-1:0];
         o.qy = {s.qy[QUO_BITS-2:0], 1'b0};
      end
      return o;
   endfunction

   assign rdy[QUO_BITS] = out_ready;
   assign in_ready      = rdy[0];

   for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
      div_type src;
      logic    src_v;
      if (s == 0) begin : g_first
         assign src   = in_data;
         assign src_v = in_valid;
      end else begin : g_next
         assign src   = st_ff[s-1];
         assign src_v = v_ff[s-1];
      end
      assign rdy[s] = !v_ff[s] || rdy[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            v_ff[s] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) st_ff[s] <= div_step(src);
      end
   end

   assign out_valid = v_ff[QUO_BITS-1];
   assign out_data  = st_ff[QUO_BITS-1];

endmodule

`default_nettype wire

// ----- src/pws_map.sv -----
// ----------------------------------------------------------------------------
// pws_map
// viewport offset, saturation and the response output register
// ----------------------------------------------------------------------------
`default_nettype none

module pws_map (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire pws_pkg::div_type              in_data,
   input  wire logic [pws_pkg::HALF_BITS-1:0] half_w,
   input  wire logic [pws_pkg::HALF_BITS-1:0] half_h,
   pws_rsp_if.source                          rsp_chan
);
   import pws_pkg::*;

   localparam logic signed [SUM_BITS-1:0] SAT_MAX =
      {{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SAT_MIN =
      {{(SUM_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   logic signed [SUM_BITS-1:0]   qx, qy, offx, offy, sumx, sumy;
   logic signed [COORD_BITS-1:0] sx, sy;
   logic                         v_ff, rdy;
   logic                         vis_ff;
   logic signed [COORD_BITS-1:0] sx_ff, sy_ff;

   function automatic logic signed [COORD_BITS-1:0] clamp(
      logic signed [SUM_BITS-1:0] v, logic ovf, logic to_max);
      logic signed [COORD_BITS-1:0] r;
      if (ovf) r = to_max ? SAT_MAX[COORD_BITS-1:0] : SAT_MIN[COORD_BITS-1:0];
      else if (v > SAT_MAX) r = SAT_MAX[COORD_BITS-1:0];
      else if (v < SAT_MIN) r = SAT_MIN[COORD_BITS-1:0];
      else r = v[COORD_BITS-1:0];
      return r;
   endfunction

   assign rdy      = !v_ff || rsp_chan.ready;
   assign in_ready = rdy;

   // signed quotients plus half extent, y axis flipped
   assign qx   = in_data.side.neg_x ? -$signed({2'b00, in_data.qx}) : $signed({2'b00, in_data.qx});
   assign qy   = in_data.side.neg_y ? -$signed({2'b00, in_data.qy}) : $signed({2'b00, in_data.qy});
   assign offx = $signed(SUM_BITS'({half_w, {FRAC_BITS{1'b0}}}));
   assign offy = $signed(SUM_BITS'({half_h, {FRAC_BITS{1'b0}}}));
   assign sumx = offx + qx;
   assign sumy = offy - qy;
   assign sx   = clamp(sumx, in_data.side.ovf_x, !in_data.side.neg_x);
   assign sy   = clamp(sumy, in_data.side.ovf_y, in_data.side.neg_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (rdy) begin
         v_ff <= in_valid;
      end
   end

   // not visible points report zero coordinates
   always_ff @(posedge clock) begin
      if (rdy) begin
         vis_ff <= in_data.side.vis;
         sx_ff  <= in_data.side.vis ? sx : '0;
         sy_ff  <= in_data.side.vis ? sy : '0;
      end
   end

   assign rsp_chan.valid    = v_ff;
   assign rsp_chan.visible  = vis_ff;
   assign rsp_chan.screen_x = sx_ff;
   assign rsp_chan.screen_y = sy_ff;

endmodule

`default_nettype wire

// ----- src/perspective_world_to_screen.sv -----
// ----------------------------------------------------------------------------
// perspective_world_to_screen
// world point to screen coordinates through a stored 4x4 matrix
// ----------------------------------------------------------------------------
// Takes one request per clock unless stalled. A load request writes one Q16.16
// matrix coefficient (column-major) and gives no response; it is seen by the
// next point request. A point request gives one response through two stages of
// clip-space products and sums, two of visibility test, scaling and divider
// setup, 33 stages of the restoring divider (one quotient bit per stage), and
// the output register. Every stage holds its item on a stall and empty stages
// fill, so requests keep flowing while a response waits, until all are full.
// Viewport registers reset to 1920 by 1080 and should be written while idle.
`default_nettype none

module perspective_world_to_screen (
   input  wire logic clock,
   input  wire logic reset,
   pws_req_if.sink   req_chan,
   pws_rsp_if.source rsp_chan,
   pws_csr_if.sink   csr_chan
);
   import pws_pkg::*;
   `include "perspective_world_to_screen_defines.svh"

   logic [DIM_BITS-1:0]  width_ff, height_ff;
   logic [HALF_BITS-1:0] half_w, half_h;
   logic                 clip_valid, clip_ready;
   clip_type             clip_data;
   logic                 prep_valid, prep_ready;
   div_type              prep_data;
   logic                 div_valid, div_ready;
   div_type              div_data;

   // viewport registers
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.addr)
            CSR_WIDTH:  width_ff  <= csr_chan.data;
            CSR_HEIGHT: height_ff <= csr_chan.data;
            default:    ;
         endcase
      end
   end

   assign half_w = width_ff[DIM_BITS-1:1];
   assign half_h = height_ff[DIM_BITS-1:1];

   pws_clip u_clip (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (clip_valid),
      .out_ready (clip_ready),
      .out_data  (clip_data)
   );

   pws_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (clip_valid),
      .in_ready  (clip_ready),
      .in_data   (clip_data),
      .half_w    (half_w),
      .half_h    (half_h),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   pws_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   pws_map u_map (
      .clock    (clock),
      .reset    (reset),
      .in_valid (div_valid),
      .in_ready (div_ready),
      .in_data  (div_data),
      .half_w   (half_w),
      .half_h   (half_h),
      .rsp_chan (rsp_chan)
   );

   // hidden points carry zero coordinates
   `PWS_ASSERT_NOW(a_hidden_zero, clock, reset, rsp_chan.valid && !rsp_chan.visible, rsp_chan.screen_x == '0 && rsp_chan.screen_y == '0)
   // a draining output leaves every stage able to move
   `PWS_ASSERT_NOW(a_drain_ready, clock, reset, rsp_chan.ready, req_chan.ready)
   // width write lands in the register
   `PWS_ASSERT_NEXT(a_width_write, clock, reset, csr_chan.valid && csr_chan.addr == CSR_WIDTH, width_ff == $past(csr_chan.data))

endmodule

`default_nettype wire
